// ----- rtl/nisw_pkg.sv -----
// Shared types, token codes and digit-group tables for the Indian-scale number reader.
package nisw_pkg;

    typedef logic [6:0] tok_t;

    localparam tok_t TOK_ZERO     = 7'd0;
    localparam tok_t TOK_HUNDRED  = 7'd100;
    localparam tok_t TOK_THOUSAND = 7'd101;
    localparam tok_t TOK_LAKH     = 7'd102;
    localparam tok_t TOK_KAROR    = 7'd103;
    localparam tok_t TOK_ARAB     = 7'd104;
    localparam tok_t TOK_KHARAB   = 7'd105;
    localparam tok_t TOK_MINUS    = 7'd106;
    localparam tok_t TOK_POINT    = 7'd107;
    localparam tok_t TOK_NAN      = 7'd108;

    localparam int NUM_DIGITS = 20;
    localparam int FRAC_DEPTH = 32;
    localparam int MAX_TOKENS = 40;
    localparam int NUM_GROUPS = 11;

    // Groups 0-4 are the count in front of kharab, 5-10 the remainder below it
    localparam logic [3:0] GRP_Q_LAST = 4'd4;
    localparam logic [3:0] GRP_LAST   = 4'd10;

    localparam logic [20:0] CP_MINUS    = 21'h0002d;
    localparam logic [20:0] CP_POINT    = 21'h0002e;
    localparam logic [20:0] CP_COMMA    = 21'h0002c;
    localparam logic [20:0] CP_AR_POINT = 21'h0066b;
    localparam logic [20:0] CP_AR_SEP   = 21'h0066c;
    localparam logic [16:0] CP_ASCII_DIGITS = 17'h00003;
    localparam logic [16:0] CP_URDU_DIGITS  = 17'h0006f;
    localparam logic [16:0] CP_ARAB_DIGITS  = 17'h00066;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_GROUP,
        SRC_FRAC
    } tok_src_t;

    typedef struct packed {
        logic       load;
        logic       gen;
        tok_src_t   src;
        tok_t       tok;
        logic [3:0] grp;
        logic [4:0] fidx;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic       invalid;
        logic       digit_seen;
        logic       negative;
        logic       point_seen;
        logic [5:0] frac_cnt;
        logic       grp_nz;
        logic       q_nz;
        logic       whole_zero;
        logic       can_push;
    } status_t;

    // Lowest BCD digit of a group
    function automatic logic [4:0] grp_lo(input logic [3:0] g);
        logic [4:0] r;
        unique case (g)
            4'd0:    r = 5'd18;
            4'd1:    r = 5'd16;
            4'd2:    r = 5'd14;
            4'd3:    r = 5'd13;
            4'd4:    r = 5'd11;
            4'd5:    r = 5'd9;
            4'd6:    r = 5'd7;
            4'd7:    r = 5'd5;
            4'd8:    r = 5'd3;
            4'd9:    r = 5'd2;
            4'd10:   r = 5'd0;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Hundred groups hold a single digit
    function automatic logic grp_two(input logic [3:0] g);
        return !(g == 4'd3 || g == 4'd9);
    endfunction

    function automatic logic grp_scaled(input logic [3:0] g);
        return !(g == GRP_Q_LAST || g == GRP_LAST);
    endfunction

    function automatic tok_t grp_scale(input logic [3:0] g);
        tok_t r;
        unique case (g)
            4'd0, 4'd6: r = TOK_KAROR;
            4'd1, 4'd7: r = TOK_LAKH;
            4'd2, 4'd8: r = TOK_THOUSAND;
            4'd3, 4'd9: r = TOK_HUNDRED;
            4'd5:       r = TOK_ARAB;
            default:    r = TOK_ZERO;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/nisw_dp.sv -----
// Datapath: word parsing into BCD, fraction store, token select and output registers.
module nisw_dp #(
    parameter int MAX_WORD_LEN = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  nisw_pkg::cmd_t    cmd,
    output nisw_pkg::status_t sts,
    input  logic [20:0]       code_point,
    output logic [6:0]        m_token,
    output logic              m_last,
    output logic              m_valid,
    input  logic              m_ready
);
    localparam int PW = $clog2(MAX_WORD_LEN + 1);
    localparam int BW = 4 * nisw_pkg::NUM_DIGITS;

    logic [BW-1:0]   bcd_reg;
    logic            neg_reg, point_reg, digit_reg, inval_reg;
    logic [PW-1:0]   pos_reg;
    logic [5:0]      fcnt_reg;
    logic [3:0]      frac_mem [nisw_pkg::FRAC_DEPTH];
    logic [3:0]      frac_rd_reg;

    nisw_pkg::tok_t  pend_reg, out_reg;
    logic            pend_valid_reg, out_valid_reg, out_last_reg;

    logic            pos_full, is_digit, is_point, is_sep, over;
    logic [3:0]      dval;
    logic [4:0]      lo;
    logic [3:0]      d_lo, d_hi;
    nisw_pkg::tok_t  grp_cnt, tok;

    assign pos_full = pos_reg >= PW'(MAX_WORD_LEN);
    assign dval     = code_point[3:0];
    assign is_digit = (code_point[20:4] == nisw_pkg::CP_ASCII_DIGITS
                    || code_point[20:4] == nisw_pkg::CP_URDU_DIGITS
                    || code_point[20:4] == nisw_pkg::CP_ARAB_DIGITS) && dval <= 4'd9;
    assign is_point = code_point == nisw_pkg::CP_POINT || code_point == nisw_pkg::CP_AR_POINT;
    assign is_sep   = code_point == nisw_pkg::CP_COMMA || code_point == nisw_pkg::CP_AR_SEP;
    // Whole part above 10^18
    assign over = (bcd_reg[79:76] != 4'd0) || (bcd_reg[75:72] > 4'd1)
               || (bcd_reg[75:72] == 4'd1 && (|bcd_reg[71:0]));

    assign lo      = nisw_pkg::grp_lo(cmd.grp);
    assign d_lo    = bcd_reg[{lo, 2'b00} +: 4];
    assign d_hi    = nisw_pkg::grp_two(cmd.grp) ? bcd_reg[{lo + 5'd1, 2'b00} +: 4] : 4'd0;
    assign grp_cnt = {d_hi, 3'b000} + {2'b00, d_hi, 1'b0} + {3'b000, d_lo};

    always_comb begin
        case (cmd.src)
            nisw_pkg::SRC_GROUP: tok = grp_cnt;
            nisw_pkg::SRC_FRAC:  tok = {3'b000, frac_rd_reg};
            default:             tok = cmd.tok;
        endcase
    end

    assign sts.invalid    = inval_reg;
    assign sts.digit_seen = digit_reg;
    assign sts.negative   = neg_reg;
    assign sts.point_seen = point_reg;
    assign sts.frac_cnt   = fcnt_reg;
    assign sts.grp_nz     = (d_lo != 4'd0) || (d_hi != 4'd0);
    assign sts.q_nz       = |bcd_reg[79:44];
    assign sts.whole_zero = ~|bcd_reg;
    assign sts.can_push   = !out_valid_reg || m_ready;

    // Fraction digits: no reset, read only below the fill count
    always_ff @(posedge aclk) begin
        if (cmd.load && !pos_full && !(pos_reg == '0 && code_point == nisw_pkg::CP_MINUS)
            && is_digit && point_reg && fcnt_reg < 6'(nisw_pkg::FRAC_DEPTH)) begin
            frac_mem[fcnt_reg[4:0]] <= dval;
        end
        // Prefetch the entry the controller walks next
        frac_rd_reg <= frac_mem[cmd.fidx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            bcd_reg   <= '0;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            digit_reg <= 1'b0;
            inval_reg <= 1'b0;
            pos_reg   <= '0;
            fcnt_reg  <= '0;
        end else if (cmd.load) begin
            if (!pos_full) pos_reg <= pos_reg + PW'(1);
            if (pos_full) begin
                inval_reg <= 1'b1;
            end else if (pos_reg == '0 && code_point == nisw_pkg::CP_MINUS) begin
                neg_reg <= 1'b1;
            end else if (is_digit) begin
                digit_reg <= 1'b1;
                if (!point_reg) begin
                    if (over) inval_reg <= 1'b1;
                    else      bcd_reg   <= {bcd_reg[BW-5:0], dval};
                end else if (fcnt_reg < 6'(nisw_pkg::FRAC_DEPTH)) begin
                    fcnt_reg <= fcnt_reg + 6'd1;
                end
            end else if (is_point && !point_reg) begin
                point_reg <= 1'b1;
            end else if (!is_sep) begin
                inval_reg <= 1'b1;
            end
        end
    end

    // One-token lookahead so the final token can carry last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (cmd.finish) begin
            out_reg        <= pend_reg;
            out_last_reg   <= 1'b1;
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
        end else if (cmd.gen) begin
            if (pend_valid_reg) begin
                out_reg       <= pend_reg;
                out_last_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            pend_reg       <= tok;
            pend_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_token = out_reg;
    assign m_last  = out_last_reg;
    assign m_valid = out_valid_reg;

endmodule

// ----- rtl/nisw_ctrl.sv -----
// Controller: accepts code points and walks the token sequence at word end.
module nisw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  nisw_pkg::status_t sts,
    output nisw_pkg::cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_WHOLE,
        ST_CNT,
        ST_SCL,
        ST_KH,
        ST_POINT,
        ST_FRAC,
        ST_FLUSH
    } state_t;

    state_t     state_reg, state_next, target;
    logic [3:0] grp_reg, grp_next;
    logic [5:0] fi_reg, fi_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [3:0] grp_after;
    state_t     st_after;

    assign s_ready = state_reg == ST_IDLE;

    // Where to go once a group is done
    always_comb begin
        grp_after = grp_reg + 4'd1;
        st_after  = ST_CNT;
        if (grp_reg == nisw_pkg::GRP_Q_LAST) begin
            st_after = ST_KH;
        end else if (grp_reg == nisw_pkg::GRP_LAST) begin
            st_after = ST_POINT;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.src    = nisw_pkg::SRC_CONST;
        cmd.grp    = grp_reg;
        target     = state_reg;
        grp_next   = grp_reg;
        fi_next    = fi_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (s_last) target = ST_START;
                end
            end
            ST_START: begin
                if (sts.invalid || !sts.digit_seen) begin
                    cmd.gen = 1'b1;
                    cmd.tok = nisw_pkg::TOK_NAN;
                    target  = ST_FLUSH;
                end else begin
                    cmd.gen = sts.negative;
                    cmd.tok = nisw_pkg::TOK_MINUS;
                    target  = ST_WHOLE;
                end
            end
            ST_WHOLE: begin
                grp_next = '0;
                if (sts.whole_zero) begin
                    cmd.gen = 1'b1;
                    cmd.tok = nisw_pkg::TOK_ZERO;
                    target  = ST_POINT;
                end else begin
                    target = ST_CNT;
                end
            end
            ST_CNT: begin
                if (sts.grp_nz) begin
                    cmd.gen = 1'b1;
                    cmd.src = nisw_pkg::SRC_GROUP;
                end
                if (sts.grp_nz && nisw_pkg::grp_scaled(grp_reg)) begin
                    target = ST_SCL;
                end else begin
                    target   = st_after;
                    grp_next = grp_after;
                end
            end
            ST_SCL: begin
                cmd.gen  = 1'b1;
                cmd.tok  = nisw_pkg::grp_scale(grp_reg);
                target   = st_after;
                grp_next = grp_after;
            end
            ST_KH: begin
                cmd.gen  = sts.q_nz;
                cmd.tok  = nisw_pkg::TOK_KHARAB;
                grp_next = nisw_pkg::GRP_Q_LAST + 4'd1;
                target   = ST_CNT;
            end
            ST_POINT: begin
                fi_next = '0;
                cmd.gen = sts.point_seen;
                cmd.tok = nisw_pkg::TOK_POINT;
                target  = sts.point_seen ? ST_FRAC : ST_FLUSH;
            end
            ST_FRAC: begin
                if (fi_reg < sts.frac_cnt) begin
                    cmd.gen = 1'b1;
                    cmd.src = nisw_pkg::SRC_FRAC;
                    fi_next = fi_reg + 6'd1;
                end else begin
                    target = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.finish = 1'b1;
                target     = ST_IDLE;
            end
            default: target = ST_IDLE;
        endcase

        state_next = target;
        if (state_reg != ST_IDLE) begin
            if (!sts.can_push) begin
                // hold everything until the output register frees up
                cmd.gen    = 1'b0;
                cmd.finish = 1'b0;
                state_next = state_reg;
                grp_next   = grp_reg;
                fi_next    = fi_reg;
            end else if (cmd.gen) begin
                cnt_next = cnt_reg + 6'd1;
                // stop after the token limit
                if (cnt_reg == 6'(nisw_pkg::MAX_TOKENS - 1)) state_next = ST_FLUSH;
            end
        end
        // fraction store read is registered: address the entry for the next cycle
        cmd.fidx = fi_next[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            grp_reg   <= '0;
            fi_reg    <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            grp_reg   <= grp_next;
            fi_reg    <= fi_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/numeral_to_indian_scale_words.sv -----
// Top level: reads a streamed word as a number and emits Indian-scale word tokens.
//
//  channel   dir  tdata                       tlast
//  s_        in   [20:0] code_point, pad 24   word_end
//  m_        out  [6:0]  token, pad 8         token_last
//
// A code point is accepted only while the controller is idle. At word end
// the controller steps through the eleven digit groups, each scale word, each
// fraction digit and its fixed steps; no input is taken meanwhile.
// Reset is synchronous on aresetn low and clears all word state but the fraction store.
// A stalled m_tready holds the token walk; tokens go through a one-deep lookahead.
module numeral_to_indian_scale_words #(
    parameter int MAX_WORD_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] token
    output logic        m_tlast
);
    nisw_pkg::cmd_t    cmd;
    nisw_pkg::status_t sts;
    logic [6:0]        token;

    nisw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_last  (s_tlast),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nisw_dp #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .code_point (s_tdata[20:0]),
        .m_token    (token),
        .m_last     (m_tlast),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready)
    );

    assign m_tdata = {1'b0, token};

endmodule

// ----- tb/numeral_to_indian_scale_words_tb.sv -----
// Self-checking testbench for the Indian-scale number reader: streams words, predicts tokens.
module numeral_to_indian_scale_words_tb;

    localparam int WORD_LEN = 32;
    localparam longint unsigned WHOLE_CAP = 64'd1000000000000000000;
    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    numeral_to_indian_scale_words #(.MAX_WORD_LEN(WORD_LEN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    typedef struct packed {
        nisw_pkg::tok_t tok;
        logic last;
    } word_tok_t;

    word_tok_t pending_tokens[$];
    int error_count = 0;
    int cycle_count = 0;
    bit stall_enable = 1'b1;

    // reader state
    longint unsigned whole_acc;
    bit neg_flag, point_flag, digit_flag, bad_flag;
    int pos_cnt, frac_cnt;
    logic [3:0] frac_store[nisw_pkg::FRAC_DEPTH];
    nisw_pkg::tok_t spoken[$];

    task automatic report(input string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    function automatic int code_digit(input logic [20:0] c);
        if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
        if (c >= 21'h6f0 && c <= 21'h6f9) return int'(c - 21'h6f0);
        if (c >= 21'h660 && c <= 21'h669) return int'(c - 21'h660);
        return -1;
    endfunction

    function automatic void say(input nisw_pkg::tok_t t);
        if (spoken.size() < nisw_pkg::MAX_TOKENS) spoken.push_back(t);
    endfunction

    function automatic void speak_whole(input longint unsigned v);
        longint unsigned sizes[6];
        nisw_pkg::tok_t names[6];
        sizes = '{64'd100000000000, 64'd1000000000, 64'd10000000, 64'd100000,
                  64'd1000, 64'd100};
        names = '{nisw_pkg::TOK_KHARAB, nisw_pkg::TOK_ARAB, nisw_pkg::TOK_KAROR,
                  nisw_pkg::TOK_LAKH, nisw_pkg::TOK_THOUSAND, nisw_pkg::TOK_HUNDRED};
        if (v == 0) begin
            say(nisw_pkg::TOK_ZERO);
            return;
        end
        for (int i = 0; i < 6; i++) begin
            if (v >= sizes[i]) begin
                speak_whole(v / sizes[i]);
                say(names[i]);
                v = v % sizes[i];
            end
        end
        if (v > 0) say(nisw_pkg::tok_t'(v));
    endfunction

    function automatic void clear_reader();
        whole_acc = 0; neg_flag = 0; point_flag = 0; digit_flag = 0;
        bad_flag = 0; pos_cnt = 0; frac_cnt = 0;
    endfunction

    function automatic void predict_code(input logic [20:0] c, input bit fin);
        int d;
        d = code_digit(c);
        if (pos_cnt >= WORD_LEN) bad_flag = 1;
        else if (pos_cnt == 0 && c == nisw_pkg::CP_MINUS) neg_flag = 1;
        else if (d >= 0) begin
            digit_flag = 1;
            if (!point_flag) begin
                if (whole_acc > WHOLE_CAP) bad_flag = 1;
                else whole_acc = whole_acc * 10 + longint'(d);
            end else if (frac_cnt < nisw_pkg::FRAC_DEPTH) begin
                frac_store[frac_cnt] = d[3:0];
                frac_cnt++;
            end
        end else if ((c == nisw_pkg::CP_POINT || c == nisw_pkg::CP_AR_POINT) && !point_flag)
            point_flag = 1;
        else if (c == nisw_pkg::CP_COMMA || c == nisw_pkg::CP_AR_SEP) ;
        else bad_flag = 1;
        if (pos_cnt < WORD_LEN) pos_cnt++;
        if (!fin) return;
        spoken.delete();
        if (bad_flag || !digit_flag) say(nisw_pkg::TOK_NAN);
        else begin
            if (neg_flag) say(nisw_pkg::TOK_MINUS);
            speak_whole(whole_acc);
            if (point_flag) begin
                say(nisw_pkg::TOK_POINT);
                for (int i = 0; i < frac_cnt; i++) say(nisw_pkg::tok_t'(frac_store[i]));
            end
        end
        foreach (spoken[i])
            pending_tokens.push_back('{tok: spoken[i], last: (i == spoken.size() - 1)});
        clear_reader();
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays high between back-to-back transfers; drop it only for a gap
    task automatic send_code(input logic [20:0] c, input bit fin);
        int g;
        g = stall_enable ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, c};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_code(c, fin);
    endtask

    task automatic send_word(input logic [20:0] w[$]);
        foreach (w[i]) send_code(w[i], i == w.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [20:0] w[$];
        for (int i = 0; i < s.len(); i++) w.push_back(21'(s[i]));
        send_word(w);
    endtask

    // receiver: random stalls, compare each transfer with the oldest expectation
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_tokens.size() == 0) report($sformatf("unexpected token %0d",
                                                                 m_tdata[6:0]));
                else begin
                    word_tok_t e;
                    e = pending_tokens.pop_front();
                    if (m_tdata[6:0] !== e.tok)
                        report($sformatf("token %0d, expected %0d", m_tdata[6:0], e.tok));
                    if (m_tlast !== e.last)
                        report($sformatf("token_last %0b, expected %0b", m_tlast, e.last));
                end
            end
            m_tready <= stall_enable ? ($urandom_range(0, 9) < 7) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [20:0] w[$];
        send_text("0");
        send_text("-9");
        send_text("99");
        send_text("100");
        send_text("1,23,45,678");
        send_text("1000000000000000000");
        send_text("10000000000000000009");   // whole part at the cap before the last digit
        send_text("99999999999999999999");
        send_text("3.14");
        send_text(".5");
        send_text("7.");
        send_text("1.2.3");                  // second decimal point
        send_text("5-");                     // minus not in front
        send_text("-");                      // no digit
        send_text("abc");
        send_text("123456789012345678901234567890123"); // too long
        send_text("0.12345678901234567890123456789012"); // too long, fraction
        w = '{21'h6f1, 21'h6f9, 21'h66b, 21'h660, 21'h669, 21'h66c, 21'h662};
        send_word(w);
        w = '{21'h1fffff, 21'h31};
        send_word(w);
        w = '{21'h10ffff};
        send_word(w);
        send_text("-12345678901234567.8901234567890");
        send_text(",");
        // many fraction digits, but one code point over the word length, so not a number
        send_text("-1.234567890123456789012345678901");
    endtask

    task automatic test_random_words(input int budget);
        logic [20:0] w[$];
        int n, k, sent;
        sent = 0;
        while (sent < budget) begin
            w.delete();
            k = $urandom_range(0, 9);
            n = (k == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                int r;
                r = $urandom_range(0, 99);
                if (i == 0 && r < 15) w.push_back(nisw_pkg::CP_MINUS);
                else if (r < 60) w.push_back(21'(21'h30 + $urandom_range(0, 9)));
                else if (r < 68) w.push_back(21'(21'h6f0 + $urandom_range(0, 9)));
                else if (r < 76) w.push_back(21'(21'h660 + $urandom_range(0, 9)));
                else if (r < 82)
                    w.push_back($urandom_range(0, 1) ? nisw_pkg::CP_POINT
                                                     : nisw_pkg::CP_AR_POINT);
                else if (r < 88)
                    w.push_back($urandom_range(0, 1) ? nisw_pkg::CP_COMMA
                                                     : nisw_pkg::CP_AR_SEP);
                else if (k < 7 && r < 95) w.push_back(21'(21'h30 + $urandom_range(0, 9)));
                else w.push_back(21'($urandom_range(0, 21'h1fffff)));
            end
            send_word(w);
            sent += n;
        end
    endtask

    task automatic test_paused_sender();
        send_text("98765");
        drain();
        send_text("-0.0");
        drain();
    endtask

    task automatic test_no_stalls();
        stall_enable = 1'b0;
        repeat (5) send_text($sformatf("%0d.%0d", $urandom, $urandom_range(0, 999)));
        stall_enable = 1'b1;
    endtask

    initial begin
        clear_reader();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_paused_sender();
        test_random_words(45);
        test_no_stalls();
        test_random_words(45);
        drain();
        repeat (100) @(posedge aclk);
        if (error_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
